@@ rtl/core/ucpb_pkg.sv @@
// Package for the unique color palette builder.
// Holds the request and result structs, the controller state type and the
// command/status bundles shared by the controller, datapath and top level.
package ucpb_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [7:0] entry_index;
        logic       was_added;
        logic       overflow;
        logic [8:0] entry_count;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ucpb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
    } ucpb_status_t;

endpackage

@@ rtl/core/ucpb_ctrl.sv @@
// Controller state machine for the palette builder.
// Depends on ucpb_pkg for the state type and command/status structs.
module ucpb_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ucpb_pkg::ucpb_status_t status,
    output ucpb_pkg::ucpb_cmd_t    cmd
);

    ucpb_pkg::state_t state_reg;
    ucpb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ucpb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ucpb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ucpb_pkg::ST_SCAN;
                end
            end
            ucpb_pkg::ST_SCAN:
            begin
                if (status.hit || status.exhausted)
                begin
                    cmd.finish = 1'b1;
                    state_next = ucpb_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = ucpb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ucpb_datapath.sv @@
// Datapath for the palette builder: palette memory, scan pipeline,
// entry counter and result register. Depends on ucpb_pkg.
module ucpb_datapath
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ucpb_pkg::pixel_t       pixel,
    input  ucpb_pkg::ucpb_cmd_t    cmd,
    output ucpb_pkg::ucpb_status_t status,
    output logic                   done,
    output ucpb_pkg::result_t      result
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

    logic [31:0]       mem [PALETTE_DEPTH];
    ucpb_pkg::pixel_t  pix_reg;
    logic [CW-1:0]     used_reg;
    logic [CW-1:0]     used_next;
    logic [CW-1:0]     scan_reg;
    logic [CW-1:0]     scan_next;
    logic [AW-1:0]     cmp_idx_reg;
    logic              cmp_valid_reg;
    logic              cmp_valid_next;
    logic [31:0]       rd_data_reg;
    logic              done_reg;
    ucpb_pkg::result_t result_reg;
    ucpb_pkg::result_t result_next;
    logic              issue;
    logic              room;
    logic              do_append;
    logic [31:0]       idx_ext;
    logic [31:0]       cnt_ext;
    logic [31:0]       used_ext;

    assign issue     = cmd.scan && (scan_reg < used_reg);
    assign room      = used_reg < DEPTH_C;
    assign status.hit = cmp_valid_reg &&
        (rd_data_reg[23:0] == {pix_reg.red, pix_reg.green, pix_reg.blue});
    // All issued reads compared and none is in flight.
    assign status.exhausted = !cmp_valid_reg && (scan_reg >= used_reg);
    assign do_append = cmd.finish && !status.hit && room;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[scan_reg[AW-1:0]];
            cmp_idx_reg <= scan_reg[AW-1:0];
        end
        if (do_append)
        begin
            mem[used_reg[AW-1:0]] <= {pix_reg.alpha, pix_reg.red,
                                      pix_reg.green, pix_reg.blue};
        end
        if (cmd.load)
        begin
            pix_reg <= pixel;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        if (cmd.load)
        begin
            scan_next      = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_valid_next = issue;
            if (issue)
            begin
                scan_next = scan_reg + CW'(1);
            end
        end
        else if (cmd.finish)
        begin
            cmp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (do_append)
        begin
            used_next = used_reg + CW'(1);
        end
        idx_ext  = 32'(cmp_idx_reg);
        cnt_ext  = 32'(used_next);
        used_ext = 32'(used_reg);
        result_next             = '0;
        result_next.entry_count = cnt_ext[8:0];
        if (status.hit)
        begin
            result_next.entry_index = idx_ext[7:0];
        end
        else if (room)
        begin
            result_next.entry_index = used_ext[7:0];
            result_next.was_added   = 1'b1;
        end
        else
        begin
            result_next.overflow = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= cmd.finish;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/unique_color_palette_builder_core.sv @@
// Unique color palette builder, top level.
// Instantiates ucpb_ctrl and ucpb_datapath; depends on ucpb_pkg.
//
// A pixel request is taken when start is high and busy is low. It is compared
// on red, green and blue against the stored entries from index 0 upward, one
// entry per cycle through the single read port of the palette memory. The
// scan stops at the first stored entry that matches, or after the last stored
// entry for a new color; busy falls in the cycle the result appears, so a new
// request is taken only once the last one is through. The result is shown for
// exactly one cycle with done high and cannot be held off, so the receiver must
// take it then. A new color is appended with its alpha; when the table is full
// it is dropped and flagged as overflow. The memory has no clearing pass: reset
// only empties the entry count.
module unique_color_palette_builder_core
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ucpb_pkg::pixel_t  pixel,
    output logic              done,
    output ucpb_pkg::result_t result
);

    ucpb_pkg::ucpb_cmd_t    cmd;
    ucpb_pkg::ucpb_status_t status;

    ucpb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    ucpb_datapath
    #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule

@@ verif/unique_color_palette_builder_core_test.sv @@
// Self-checking testbench for unique_color_palette_builder_core.
// Depends on ucpb_pkg for the pixel and result structs. A palette lookup
// model predicts every result, and each result is checked field by field.
`timescale 1ns / 100ps

module unique_color_palette_builder_core_test;

    localparam int TABLE_DEPTH  = 256;
    localparam int RANDOM_REQS  = 900;
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_PRINTED  = 40;

    typedef struct {
        ucpb_pkg::pixel_t px;
        int unsigned      gap;
        bit               drain;
    } pixel_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    ucpb_pkg::pixel_t  pixel = '0;
    logic              busy;
    logic              done;
    ucpb_pkg::result_t result;

    // Testbench copy of the palette: {alpha, red, green, blue} per entry.
    logic [31:0] color_table [TABLE_DEPTH];
    int          color_count = 0;
    int          added_total = 0;
    int          matched_total = 0;
    int          overflow_total = 0;

    pixel_req_t        pending_pixels [$];
    ucpb_pkg::result_t expected_results [$];
    logic [23:0]       seen_colors [$];
    int                issued_count = 0;
    int                checked_count = 0;
    int                total_reqs = 0;
    int                error_count = 0;
    int                gap_count = 0;
    int                quiet_cycles = 0;

    unique_color_palette_builder_core #(
        .PALETTE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Searches the palette from index 0 upward; a miss appends while room is left.
    function automatic ucpb_pkg::result_t lookup_pixel(input ucpb_pkg::pixel_t px);
        ucpb_pkg::result_t res;
        int                hit_idx;
        res = '0;
        hit_idx = -1;
        for (int i = 0; i < color_count; i++)
        begin
            if (hit_idx < 0 && color_table[i][23:0] == {px.red, px.green, px.blue})
                hit_idx = i;
        end
        if (hit_idx >= 0)
        begin
            res.entry_index = hit_idx[7:0];
            matched_total++;
        end
        else if (color_count < TABLE_DEPTH)
        begin
            color_table[color_count] = {px.alpha, px.red, px.green, px.blue};
            res.entry_index = color_count[7:0];
            res.was_added = 1'b1;
            color_count++;
            added_total++;
        end
        else
        begin
            res.overflow = 1'b1;
            overflow_total++;
        end
        res.entry_count = color_count[8:0];
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a,
                                        input int unsigned gap, input bit drain);
        pixel_req_t req;
        req.px.red = r;
        req.px.green = g;
        req.px.blue = b;
        req.px.alpha = a;
        req.gap = gap;
        req.drain = drain;
        pending_pixels.insert(pending_pixels.size(), req);
        seen_colors.insert(seen_colors.size(), {r, g, b});
        total_reqs++;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Driver: presents the next request once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pixel <= '0;
            gap_count <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(), lookup_pixel(pixel));
                issued_count <= issued_count + 1;
            end
            if (!start || !busy)
            begin
                if (pending_pixels.size() == 0)
                    start <= 1'b0;
                else if (pending_pixels[0].drain
                         && ((start && !busy) || issued_count != checked_count))
                    start <= 1'b0;
                else if (gap_count < pending_pixels[0].gap)
                begin
                    gap_count <= gap_count + 1;
                    start <= 1'b0;
                end
                else
                begin
                    pixel <= pending_pixels[0].px;
                    pending_pixels.pop_front();
                    start <= 1'b1;
                    gap_count <= 0;
                end
            end
        end
    end

    // Monitor: the receiver takes every result in the cycle it is shown.
    always @(posedge clk)
    begin
        ucpb_pkg::result_t want;
        if (rst_n && done)
        begin
            if (checked_count >= issued_count)
            begin
                flag_error($sformatf("result with no request outstanding: %p", result));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.entry_index !== want.entry_index)
                    flag_error($sformatf("entry_index got %0d, want %0d",
                                         result.entry_index, want.entry_index));
                if (result.was_added !== want.was_added)
                    flag_error($sformatf("was_added got %b, want %b",
                                         result.was_added, want.was_added));
                if (result.overflow !== want.overflow)
                    flag_error($sformatf("overflow got %b, want %b",
                                         result.overflow, want.overflow));
                if (result.entry_count !== want.entry_count)
                    flag_error($sformatf("entry_count got %0d, want %0d",
                                         result.entry_count, want.entry_count));
                checked_count <= checked_count + 1;
            end
        end
    end

    // Watchdog: fails the run once the idle count since the last accepted request or result reaches QUIET_LIMIT.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [23:0] rgb;
        bit          drain;

        // Corners of the fields, alpha ignored on a match, single-bit color
        // differences, and a match on the most recent entry.
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0);
        queue_pixel(8'hff, 8'hff, 8'hff, 8'hff, 0, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1, 1'b0);
        queue_pixel(8'hff, 8'hff, 8'hff, 8'h00, 0, 1'b0);
        queue_pixel(8'hff, 8'h00, 8'h00, 8'h80, 0, 1'b0);
        queue_pixel(8'h00, 8'hff, 8'h00, 8'h01, 2, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'hff, 8'hfe, 0, 1'b0);
        queue_pixel(8'haa, 8'h55, 8'haa, 8'h55, 0, 1'b0);
        queue_pixel(8'h55, 8'haa, 8'h55, 8'haa, 0, 1'b0);
        queue_pixel(8'hff, 8'hff, 8'hfe, 8'h7f, 1, 1'b0);
        queue_pixel(8'hfe, 8'hff, 8'hff, 8'h00, 0, 1'b0);
        queue_pixel(8'h01, 8'h00, 8'h00, 8'h00, 0, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h01, 8'h00, 0, 1'b0);
        queue_pixel(8'haa, 8'h55, 8'haa, 8'h00, 3, 1'b0);
        queue_pixel(8'h00, 8'h00, 8'h01, 8'hff, 0, 1'b0);

        // Random part: repeats of earlier colors mixed with new ones, enough to
        // fill the table and then push it into overflow.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            drain = (n == 0) || ($urandom_range(0, 149) == 0);
            if ($urandom_range(0, 99) < 60)
                rgb = seen_colors[$urandom_range(0, seen_colors.size() - 1)];
            else
                rgb = 24'($urandom);
            queue_pixel(rgb[23:16], rgb[15:8], rgb[7:0], 8'($urandom),
                        (n % 200 < 40) ? 0 : pick_gap(), drain);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (issued_count != total_reqs || checked_count != issued_count)
            @(negedge clk);
        repeat (TABLE_DEPTH + 8) @(negedge clk);

        $display("Checked %0d of %0d pixel requests: %0d added, %0d matched, %0d overflowed.",
                 checked_count, total_reqs, added_total, matched_total, overflow_total);
        $display("Palette ended with %0d of %0d entries; %0d mismatches.",
                 color_count, TABLE_DEPTH, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ucpb_pkg.sv
rtl/core/ucpb_ctrl.sv
rtl/core/ucpb_datapath.sv
rtl/core/unique_color_palette_builder_core.sv
verif/unique_color_palette_builder_core_test.sv
